[rtl/sttu_pkg.sv]
// Shared types, constants and keyword tables for the source text tokenizer.
// Used by every module of the tokenizer; depends on nothing.
package sttu_pkg;

   localparam int OffsetBits  = 16;
   localparam int LenBits     = 16;
   localparam int NumKeywords = 11;
   localparam int FifoDepth   = 4;
   localparam int FifoPtrBits = $clog2(FifoDepth);

   localparam logic [NumKeywords-1:0] KwAll = '1;

   // Keywords stored right-aligned: the first character sits in the top used byte.
   localparam logic [39:0] KwText [NumKeywords] = '{
      "ana", "tam", "metin", "dizi", "nesne", "metot",
      "kes", "devam", "yeni", "bu", "enum"
   };
   localparam logic [2:0] KwLen [NumKeywords] = '{
      3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd5, 3'd3, 3'd5, 3'd4, 3'd2, 3'd4
   };

   localparam logic [7:0] ChTab      = 8'h09;
   localparam logic [7:0] ChNewline  = 8'h0A;
   localparam logic [7:0] ChCr       = 8'h0D;
   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChBang     = 8'h21;
   localparam logic [7:0] ChDquote   = 8'h22;
   localparam logic [7:0] ChPercent  = 8'h25;
   localparam logic [7:0] ChAmp      = 8'h26;
   localparam logic [7:0] ChSquote   = 8'h27;
   localparam logic [7:0] ChLparen   = 8'h28;
   localparam logic [7:0] ChRparen   = 8'h29;
   localparam logic [7:0] ChStar     = 8'h2A;
   localparam logic [7:0] ChPlus     = 8'h2B;
   localparam logic [7:0] ChComma    = 8'h2C;
   localparam logic [7:0] ChMinus    = 8'h2D;
   localparam logic [7:0] ChDot      = 8'h2E;
   localparam logic [7:0] ChSlash    = 8'h2F;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;
   localparam logic [7:0] ChSemi     = 8'h3B;
   localparam logic [7:0] ChLess     = 8'h3C;
   localparam logic [7:0] ChEqual    = 8'h3D;
   localparam logic [7:0] ChGreater  = 8'h3E;
   localparam logic [7:0] ChUpperA   = 8'h41;
   localparam logic [7:0] ChUpperZ   = 8'h5A;
   localparam logic [7:0] ChLbrack   = 8'h5B;
   localparam logic [7:0] ChRbrack   = 8'h5D;
   localparam logic [7:0] ChUnder    = 8'h5F;
   localparam logic [7:0] ChLowerA   = 8'h61;
   localparam logic [7:0] ChLowerZ   = 8'h7A;
   localparam logic [7:0] ChLbrace   = 8'h7B;
   localparam logic [7:0] ChBar      = 8'h7C;
   localparam logic [7:0] ChRbrace   = 8'h7D;

   typedef enum logic [2:0] {
      ModeIdle    = 3'd0,
      ModeNumber  = 3'd1,
      ModeString  = 3'd2,
      ModeIdent   = 3'd3,
      ModeComment = 3'd4,
      ModeOper    = 3'd5,
      ModeSlash   = 3'd6
   } scan_mode_type;

   typedef enum logic [4:0] {
      KindNumber    = 5'd0,
      KindString    = 5'd1,
      KindKeyword   = 5'd2,
      KindIdent     = 5'd3,
      KindComment   = 5'd4,
      KindOperRun   = 5'd5,
      KindAddAssign = 5'd6,
      KindSubAssign = 5'd7,
      KindMulAssign = 5'd8,
      KindDivAssign = 5'd9,
      KindModAssign = 5'd10,
      KindIncr      = 5'd11,
      KindDecr      = 5'd12,
      KindLogAnd    = 5'd13,
      KindLogOr     = 5'd14,
      KindEq        = 5'd15,
      KindNe        = 5'd16,
      KindLe        = 5'd17,
      KindGe        = 5'd18,
      KindAssign    = 5'd19,
      KindAnd       = 5'd20,
      KindOr        = 5'd21,
      KindShl       = 5'd22,
      KindShr       = 5'd23,
      KindBracket   = 5'd24,
      KindComma     = 5'd25,
      KindSemicolon = 5'd26,
      KindDot       = 5'd27,
      KindError     = 5'd28
   } token_kind_type;

   typedef struct packed {
      token_kind_type       kind;
      logic [15:0]          start;
      logic [LenBits-1:0]   length;
      logic                 unterminated;
      logic                 run_last;
   } token_type;

   // Up to two tokens leave the scanner for one text byte.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } scan_out_type;

endpackage

[rtl/sttu_scan.sv]
// Tokenizer scanner: scan state registers and the per-byte classification logic.
// Depends on sttu_pkg for the token types, character codes and keyword table.
module sttu_scan
   import sttu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   text_byte,
   input  logic         end_of_text,
   output scan_out_type scan_out
);

   scan_mode_type            mode_ff, mode_in;
   logic                     quote_dbl_ff, quote_dbl_in;
   logic [OffsetBits-1:0]    offset_ff, offset_in;
   logic [OffsetBits-1:0]    begin_ff, begin_in;
   logic [LenBits-1:0]       len_ff, len_in;
   logic [15:0]              head_ff, head_in;
   logic [NumKeywords-1:0]   alive_ff, alive_in;

   logic      go_start;
   logic      close_v, single_v, eot_v;
   token_type close_t, single_t, eot_t;
   logic [7:0] c;

   function automatic logic is_space(input logic [7:0] ch);
      return ch == ChSpace || (ch >= ChTab && ch <= ChCr);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= ChZero && ch <= ChNine;
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= ChLowerA && ch <= ChLowerZ) || (ch >= ChUpperA && ch <= ChUpperZ);
   endfunction

   function automatic logic is_word(input logic [7:0] ch);
      return is_alpha(ch) || is_digit(ch) || ch == ChUnder;
   endfunction

   function automatic logic is_op(input logic [7:0] ch);
      return ch == ChPlus || ch == ChMinus || ch == ChStar || ch == ChSlash ||
             ch == ChPercent || ch == ChEqual || ch == ChAmp || ch == ChBar ||
             ch == ChLess || ch == ChGreater || ch == ChBang;
   endfunction

   function automatic logic is_bracket(input logic [7:0] ch);
      return ch == ChLparen || ch == ChRparen || ch == ChLbrace ||
             ch == ChRbrace || ch == ChLbrack || ch == ChRbrack;
   endfunction

   function automatic logic [LenBits-1:0] sat_inc(input logic [LenBits-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] to_start(input logic [OffsetBits-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic token_type make_token(input token_kind_type kind,
                                            input logic [OffsetBits-1:0] start,
                                            input logic [LenBits-1:0] length,
                                            input logic unterminated);
      token_type t;
      t.kind         = kind;
      t.start        = to_start(start);
      t.length       = length;
      t.unterminated = unterminated;
      t.run_last     = 1'b0;
      return t;
   endfunction

   // Every keyword still alive compares its character at the current position.
   function automatic logic [NumKeywords-1:0] kw_next(input logic [NumKeywords-1:0] alive,
                                                      input logic [LenBits-1:0] len,
                                                      input logic [7:0] ch);
      logic [NumKeywords-1:0] nxt;
      int sh;
      nxt = '0;
      for (int k = 0; k < NumKeywords; k++) begin
         if (alive[k] && len < LenBits'(KwLen[k])) begin
            sh = 8 * (int'(KwLen[k]) - 1 - int'(len[2:0]));
            if (KwText[k][sh +: 8] == ch) begin
               nxt[k] = 1'b1;
            end
         end
      end
      return nxt;
   endfunction

   function automatic token_kind_type ident_kind(input logic [NumKeywords-1:0] alive,
                                                 input logic [LenBits-1:0] len);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NumKeywords; k++) begin
         if (alive[k] && len == LenBits'(KwLen[k])) begin
            hit = 1'b1;
         end
      end
      return hit ? KindKeyword : KindIdent;
   endfunction

   function automatic token_kind_type oper_kind(input logic [15:0] head,
                                                input logic [LenBits-1:0] len);
      logic [7:0] a;
      logic [7:0] b;
      token_kind_type kind;
      a = head[7:0];
      b = head[15:8];
      kind = KindOperRun;
      if (len == LenBits'(1)) begin
         priority if (a == ChEqual) kind = KindAssign;
         else if (a == ChAmp)       kind = KindAnd;
         else if (a == ChBar)       kind = KindOr;
         else                       kind = KindOperRun;
      end else if (len == LenBits'(2)) begin
         if (b == ChEqual) begin
            priority if (a == ChPlus)  kind = KindAddAssign;
            else if (a == ChMinus)     kind = KindSubAssign;
            else if (a == ChStar)      kind = KindMulAssign;
            else if (a == ChSlash)     kind = KindDivAssign;
            else if (a == ChPercent)   kind = KindModAssign;
            else if (a == ChEqual)     kind = KindEq;
            else if (a == ChBang)      kind = KindNe;
            else if (a == ChLess)      kind = KindLe;
            else if (a == ChGreater)   kind = KindGe;
            else                       kind = KindOperRun;
         end else if (a == b) begin
            priority if (a == ChPlus)  kind = KindIncr;
            else if (a == ChMinus)     kind = KindDecr;
            else if (a == ChAmp)       kind = KindLogAnd;
            else if (a == ChBar)       kind = KindLogOr;
            else if (a == ChLess)      kind = KindShl;
            else if (a == ChGreater)   kind = KindShr;
            else                       kind = KindOperRun;
         end
      end
      return kind;
   endfunction

   assign c = text_byte;

   always_comb begin
      mode_in      = mode_ff;
      quote_dbl_in = quote_dbl_ff;
      offset_in    = offset_ff;
      begin_in     = begin_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      alive_in     = alive_ff;
      go_start     = 1'b0;
      close_v      = 1'b0;
      single_v     = 1'b0;
      eot_v        = 1'b0;
      close_t      = make_token(KindError, '0, '0, 1'b0);
      single_t     = close_t;
      eot_t        = close_t;

      // The open token either grows by this byte or closes before it.
      unique case (mode_ff)
         ModeNumber: begin
            if (is_digit(c) || c == ChDot) begin
               len_in = sat_inc(len_ff);
            end else begin
               close_v  = 1'b1;
               close_t  = make_token(KindNumber, begin_ff, len_ff, 1'b0);
               go_start = 1'b1;
            end
         end
         ModeIdent: begin
            if (is_word(c)) begin
               alive_in = kw_next(alive_ff, len_ff, c);
               len_in   = sat_inc(len_ff);
            end else begin
               close_v  = 1'b1;
               close_t  = make_token(ident_kind(alive_ff, len_ff), begin_ff, len_ff, 1'b0);
               go_start = 1'b1;
            end
         end
         ModeSlash: begin
            if (c == ChSlash) begin
               mode_in = ModeComment;
               len_in  = LenBits'(2);
            end else if (is_op(c)) begin
               mode_in = ModeOper;
               head_in = {c, ChSlash};
               len_in  = LenBits'(2);
            end else begin
               // A lone slash is an operator run of one byte with no listed form.
               close_v  = 1'b1;
               close_t  = make_token(KindOperRun, begin_ff, LenBits'(1), 1'b0);
               go_start = 1'b1;
            end
         end
         ModeOper: begin
            if (is_op(c)) begin
               if (len_ff == LenBits'(1)) begin
                  head_in = {c, head_ff[7:0]};
               end
               len_in = sat_inc(len_ff);
            end else begin
               close_v  = 1'b1;
               close_t  = make_token(oper_kind(head_ff, len_ff), begin_ff, len_ff, 1'b0);
               go_start = 1'b1;
            end
         end
         ModeString: begin
            if (c == (quote_dbl_ff ? ChDquote : ChSquote)) begin
               close_v = 1'b1;
               close_t = make_token(KindString, begin_ff, len_ff, 1'b0);
               mode_in = ModeIdle;
            end else begin
               len_in = sat_inc(len_ff);
            end
         end
         ModeComment: begin
            if (c == ChNewline) begin
               close_v = 1'b1;
               close_t = make_token(KindComment, begin_ff, len_ff, 1'b0);
               mode_in = ModeIdle;
            end else begin
               len_in = sat_inc(len_ff);
            end
         end
         default: begin
            go_start = 1'b1;
         end
      endcase

      // The byte opens a new token, or is a token of one byte by itself.
      if (go_start) begin
         mode_in = ModeIdle;
         if (!is_space(c)) begin
            begin_in = offset_ff;
            len_in   = LenBits'(1);
            priority if (is_digit(c)) begin
               mode_in = ModeNumber;
            end else if (c == ChDquote || c == ChSquote) begin
               mode_in      = ModeString;
               quote_dbl_in = (c == ChDquote);
               begin_in     = offset_ff + 1'b1;
               len_in       = '0;
            end else if (is_alpha(c)) begin
               mode_in  = ModeIdent;
               alive_in = kw_next(KwAll, '0, c);
            end else if (c == ChSlash) begin
               mode_in = ModeSlash;
            end else if (is_op(c)) begin
               mode_in = ModeOper;
               head_in = {8'h00, c};
            end else if (is_bracket(c)) begin
               single_v = 1'b1;
               single_t = make_token(KindBracket, offset_ff, LenBits'(1), 1'b0);
            end else if (c == ChComma) begin
               single_v = 1'b1;
               single_t = make_token(KindComma, offset_ff, LenBits'(1), 1'b0);
            end else if (c == ChSemi) begin
               single_v = 1'b1;
               single_t = make_token(KindSemicolon, offset_ff, LenBits'(1), 1'b0);
            end else if (c == ChDot) begin
               single_v = 1'b1;
               single_t = make_token(KindDot, offset_ff, LenBits'(1), 1'b0);
            end else begin
               single_v = 1'b1;
               single_t = make_token(KindError, offset_ff, LenBits'(1), 1'b0);
            end
         end
      end

      // End of text closes whatever is still open and returns to the reset state.
      if (end_of_text) begin
         unique case (mode_in)
            ModeNumber: begin
               eot_v = 1'b1;
               eot_t = make_token(KindNumber, begin_in, len_in, 1'b0);
            end
            ModeString: begin
               eot_v = 1'b1;
               eot_t = make_token(KindString, begin_in, len_in, 1'b1);
            end
            ModeIdent: begin
               eot_v = 1'b1;
               eot_t = make_token(ident_kind(alive_in, len_in), begin_in, len_in, 1'b0);
            end
            ModeComment: begin
               eot_v = 1'b1;
               eot_t = make_token(KindComment, begin_in, len_in, 1'b0);
            end
            ModeOper: begin
               eot_v = 1'b1;
               eot_t = make_token(oper_kind(head_in, len_in), begin_in, len_in, 1'b0);
            end
            ModeSlash: begin
               eot_v = 1'b1;
               eot_t = make_token(KindOperRun, begin_in, LenBits'(1), 1'b0);
            end
            default: begin
               eot_v = 1'b0;
            end
         endcase
         mode_in      = ModeIdle;
         quote_dbl_in = 1'b0;
         offset_in    = '0;
         begin_in     = '0;
         len_in       = '0;
         head_in      = '0;
         alive_in     = KwAll;
      end else begin
         offset_in = offset_ff + 1'b1;
      end
   end

   // A byte opening a single-byte token never leaves a token open, so at most
   // one of the late emissions is present.
   always_comb begin
      scan_out.first  = close_v ? close_t : (single_v ? single_t : eot_t);
      scan_out.second = single_v ? single_t : eot_t;
      if (!fire) begin
         scan_out.count = 2'd0;
      end else begin
         scan_out.count = 2'(close_v) + 2'(single_v | eot_v);
      end
      if (close_v && (single_v || eot_v)) begin
         scan_out.second.run_last = 1'b1;
      end else begin
         scan_out.first.run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeIdle;
         quote_dbl_ff <= 1'b0;
         offset_ff    <= '0;
         begin_ff     <= '0;
         len_ff       <= '0;
         head_ff      <= '0;
         alive_ff     <= KwAll;
      end else if (fire) begin
         mode_ff      <= mode_in;
         quote_dbl_ff <= quote_dbl_in;
         offset_ff    <= offset_in;
         begin_ff     <= begin_in;
         len_ff       <= len_in;
         head_ff      <= head_in;
         alive_ff     <= alive_in;
      end
   end

   a_eot_returns_to_start: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_text |=> mode_ff == ModeIdle && offset_ff == '0 && len_ff == '0)
      else $error("scanner state not cleared after end of text");

   a_offset_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(offset_ff) && $stable(mode_ff))
      else $error("scanner state moved without a byte");

   a_last_marks_final: assert property (@(posedge clock) disable iff (reset)
      scan_out.count == 2'd2 |-> scan_out.second.run_last && !scan_out.first.run_last)
      else $error("run_last not on the final token of a byte");

   a_no_tokens_mid_string: assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == ModeString && !end_of_text && c != ChDquote && c != ChSquote
      |-> scan_out.count == 2'd0)
      else $error("token emitted inside an open string");

endmodule

[rtl/sttu_out_fifo.sv]
// Result queue of the tokenizer: takes up to two tokens a cycle, hands out one while out_stall is low.
// Depends on sttu_pkg for the token type and queue depth.
module sttu_out_fifo
   import sttu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  scan_out_type push_data,
   output logic         room_for_two,
   output logic         out_valid,
   input  logic         out_stall,
   output token_type    out_token
);

   token_type                 entry_ff [FifoDepth];
   logic [FifoPtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrBits:0]      count_ff, count_in;
   logic [FifoPtrBits-1:0]    wr_ptr_next;
   logic                      pop;

   assign out_valid    = count_ff != '0;
   assign out_token    = entry_ff[rd_ptr_ff];
   assign room_for_two = count_ff <= (FifoPtrBits+1)'(FifoDepth - 2);
   assign pop          = out_valid && !out_stall;
   assign wr_ptr_next  = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrBits'(push_data.count);
      rd_ptr_in = rd_ptr_ff + FifoPtrBits'(pop);
      count_in  = count_ff + (FifoPtrBits+1)'(push_data.count) - (FifoPtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_data.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_data.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data.second;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FifoPtrBits+1)'(FifoDepth))
      else $error("result queue count beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_data.count != 2'd0 |-> room_for_two)
      else $error("push into a result queue without room");

   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push_data.count == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count wrong after a pop");

endmodule

[rtl/source_text_tokenizer_unit.sv]
// Top level of the streaming source text tokenizer: input register, scanner, result queue.
// Depends on sttu_pkg, sttu_scan and sttu_out_fifo.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  text_byte, end_of_text
//   rsp_      out        rsp_valid / rsp_stall  token_kind, token_start, token_length,
//                                               unterminated, run_last
//
// One text byte is taken per cycle while req_stall is low; it is registered, then its tokens pass through the queue.
// A byte that closes one token and opens a single-byte one yields two transactions,
// which leave one per cycle from a four-entry queue; input stalls while more than
// two results wait. Reset is synchronous and returns the scanner to offset zero.
// The result side may stall for any length of time without loss.
module source_text_tokenizer_unit
   import sttu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_unterminated,
   output logic        rsp_run_last
);

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_eot_ff;
   logic         room_for_two;
   logic         fire;
   scan_out_type scan_out;
   token_type    out_token;

   assign fire      = in_valid_ff && room_for_two;
   assign req_stall = in_valid_ff && !room_for_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   sttu_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .scan_out    (scan_out)
   );

   sttu_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_data    (scan_out),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_token    (out_token)
   );

   assign rsp_token_kind   = out_token.kind;
   assign rsp_token_start  = out_token.start;
   assign rsp_token_length = out_token.length;
   assign rsp_unterminated = out_token.unterminated;
   assign rsp_run_last     = out_token.run_last;

endmodule
